@@ rtl/srf_pkg.sv @@
// Package for the spectrogram row block: sizes, request types, controller codes,
// fixed-point helpers and the window and twiddle tables.
// Used by the controller, datapath and top level; depends on nothing.
`timescale 1ns / 1ps

package srf_pkg;

  localparam int N_PTS    = 512;
  localparam int LOG2_N   = 9;
  localparam int N_BINS   = 128;
  localparam int N_BFLY   = N_PTS / 2;
  localparam int N_STAGES = LOG2_N;
  localparam int SQ_ITERS = 16;

  localparam logic [63:0] S_A1 = 64'd1686629713;
  localparam logic [63:0] S_A3 = 64'd693598668;
  localparam logic [63:0] S_A5 = 64'd85569307;
  localparam logic [63:0] S_A7 = 64'd5026995;
  localparam logic [63:0] S_A9 = 64'd172272;

  localparam logic signed [26:0] DB_PER_LOG2 = 27'sd50504453;
  localparam logic signed [47:0] W24_MAX = 48'sd8388607;
  localparam logic signed [47:0] W24_MIN = -48'sd8388608;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               snapshot;
  } in_req_t;

  typedef struct packed {
    logic [5:0] bin_pair;
    logic [9:0] level_even;
    logic [9:0] level_odd;
    logic [5:0] row_number;
    logic       last_of_row;
  } out_req_t;

  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_LD_RD   = 18'b000000000000000010,
    S_LD_MUL  = 18'b000000000000000100,
    S_LD_WR   = 18'b000000000000001000,
    S_BF_RA   = 18'b000000000000010000,
    S_BF_RB   = 18'b000000000000100000,
    S_BF_MUL  = 18'b000000000001000000,
    S_BF_ADD  = 18'b000000000010000000,
    S_BF_WA   = 18'b000000000100000000,
    S_BF_WB   = 18'b000000001000000000,
    S_MG_RD   = 18'b000000010000000000,
    S_MG_MUL  = 18'b000000100000000000,
    S_MG_SUM  = 18'b000001000000000000,
    S_MG_NORM = 18'b000010000000000000,
    S_MG_SQ   = 18'b000100000000000000,
    S_MG_DB   = 18'b001000000000000000,
    S_MG_LVL  = 18'b010000000000000000,
    S_MG_FIN  = 18'b100000000000000000
  } state_t;

  typedef struct packed {
    state_t     op;
    logic       store;
    logic [8:0] idx;
    logic [3:0] stage;
  } srf_cmd_t;

  typedef struct packed {
    logic pw_zero;
    logic norm_top;
  } srf_stat_t;

  typedef logic [N_PTS-1:0][17:0]   win_rom_t;
  typedef logic [N_BFLY-1:0][31:0]  tw_rom_t;

  function automatic logic signed [17:0] sin_fix(input logic [31:0] ph, input int fb);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] mag;
    r  = {34'd0, ph[29:0]};
    x  = ph[30] ? ((64'd1 << 30) - r) : r;
    x2 = (x * x) >> 30;
    p  = S_A7 - ((x2 * S_A9) >> 30);
    p  = S_A5 - ((x2 * p) >> 30);
    p  = S_A3 - ((x2 * p) >> 30);
    p  = S_A1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    mag = (s + (64'd1 << (29 - fb))) >> (30 - fb);
    if (mag > (64'd1 << fb)) mag = 64'd1 << fb;
    return ph[31] ? -$signed(mag[17:0]) : $signed(mag[17:0]);
  endfunction

  function automatic win_rom_t make_win();
    win_rom_t    t;
    logic [63:0] ph;
    for (int i = 0; i < N_PTS; i++) begin
      ph   = ((64'(i) << 32) + 64'((N_PTS - 1) / 2)) / 64'(N_PTS - 1);
      t[i] = 18'(18'sd32768 - sin_fix(ph[31:0] + 32'h4000_0000, 15));
    end
    return t;
  endfunction

  function automatic tw_rom_t make_tw();
    tw_rom_t          t;
    logic [31:0]      ph;
    logic signed [17:0] wr;
    logic signed [17:0] wi;
    for (int k = 0; k < N_BFLY; k++) begin
      ph   = 32'd0 - (32'(k) << (32 - LOG2_N));
      wr   = sin_fix(ph + 32'h4000_0000, 14);
      wi   = sin_fix(ph, 14);
      t[k] = {wr[15:0], wi[15:0]};
    end
    return t;
  endfunction

  localparam win_rom_t WIN_ROM = make_win();
  localparam tw_rom_t  TW_ROM  = make_tw();

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > W24_MAX) return W24_MAX[23:0];
    if (v < W24_MIN) return W24_MIN[23:0];
    return v[23:0];
  endfunction

  function automatic logic [LOG2_N-1:0] bit_rev(input logic [LOG2_N-1:0] v);
    logic [LOG2_N-1:0] o;
    for (int b = 0; b < LOG2_N; b++) o[b] = v[LOG2_N-1-b];
    return o;
  endfunction

endpackage

@@ rtl/srf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module srf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/srf_ctrl.sv @@
// Controller for the spectrogram row block: sequences loading, the FFT stages
// and the level conversion. Depends on srf_pkg.
`timescale 1ns / 1ps

module srf_ctrl
  import srf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      snapshot,
  input  srf_stat_t stat,
  output srf_cmd_t  cmd,
  output logic      busy
);

  state_t     state_r, state_nxt;
  logic [8:0] idx_r, idx_nxt;
  logic [3:0] stage_r, stage_nxt;
  logic [3:0] sq_r, sq_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    stage_nxt = stage_r;
    sq_nxt    = sq_r;
    case (state_r)
      S_IDLE: begin
        if (start && snapshot) begin
          state_nxt = S_LD_RD;
          idx_nxt   = '0;
        end
      end
      S_LD_RD:  state_nxt = S_LD_MUL;
      S_LD_MUL: state_nxt = S_LD_WR;
      S_LD_WR: begin
        if (idx_r == 9'(N_PTS - 1)) begin
          state_nxt = S_BF_RA;
          idx_nxt   = '0;
          stage_nxt = 4'd1;
        end else begin
          state_nxt = S_LD_RD;
          idx_nxt   = idx_r + 9'd1;
        end
      end
      S_BF_RA:  state_nxt = S_BF_RB;
      S_BF_RB:  state_nxt = S_BF_MUL;
      S_BF_MUL: state_nxt = S_BF_ADD;
      S_BF_ADD: state_nxt = S_BF_WA;
      S_BF_WA:  state_nxt = S_BF_WB;
      S_BF_WB: begin
        idx_nxt = idx_r + 9'd1;
        state_nxt = S_BF_RA;
        if (idx_r == 9'(N_BFLY - 1)) begin
          idx_nxt = '0;
          if (stage_r == 4'(N_STAGES)) begin
            state_nxt = S_MG_RD;
          end else begin
            stage_nxt = stage_r + 4'd1;
          end
        end
      end
      S_MG_RD:  state_nxt = S_MG_MUL;
      S_MG_MUL: state_nxt = S_MG_SUM;
      S_MG_SUM: state_nxt = S_MG_NORM;
      S_MG_NORM: begin
        if (stat.pw_zero) begin
          state_nxt = S_MG_LVL;
        end else if (stat.norm_top) begin
          state_nxt = S_MG_SQ;
          sq_nxt    = '0;
        end
      end
      S_MG_SQ: begin
        sq_nxt = sq_r + 4'd1;
        if (sq_r == 4'(SQ_ITERS - 1)) state_nxt = S_MG_DB;
      end
      S_MG_DB:  state_nxt = S_MG_LVL;
      S_MG_LVL: state_nxt = S_MG_FIN;
      S_MG_FIN: begin
        if (idx_r == 9'(N_BINS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MG_RD;
          idx_nxt   = idx_r + 9'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      stage_r <= 4'd1;
      sq_r    <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stage_r <= stage_nxt;
      sq_r    <= sq_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.op    = state_r;
  assign cmd.store = start && (state_r == S_IDLE);
  assign cmd.idx   = idx_r;
  assign cmd.stage = stage_r;

endmodule

@@ rtl/srf_dp.sv @@
// Datapath for the spectrogram row block: sample ring, work memory, butterfly
// and level arithmetic, output register. Depends on srf_pkg and srf_ram.
`timescale 1ns / 1ps

module srf_dp
  import srf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  srf_cmd_t  cmd,
  input  in_req_t   in_req,
  output srf_stat_t stat,
  output out_req_t  out_req,
  output logic      out_strobe
);

  logic [8:0]  wp_r;
  logic [9:0]  fill_r;
  logic [8:0]  haddr;
  logic [15:0] hrdata;

  logic        wk_we;
  logic [8:0]  wk_waddr, wk_raddr;
  logic [47:0] wk_wdata, wk_rdata;

  logic [8:0]  half9, hmask, addr_a, addr_b;
  logic [7:0]  tw_idx;

  logic signed [17:0] win_r;
  logic               hv_r;
  logic signed [33:0] lprod_r;
  logic signed [15:0] lx;

  logic signed [23:0] a_re_r, a_im_r;
  logic [31:0]        tw_r;
  logic signed [15:0] wr, wi;
  logic signed [39:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [41:0] ur, ui, vr, vi;
  logic signed [23:0] ar_r, ai_r, br_r, bi_r;
  logic signed [23:0] rd_re, rd_im;

  logic [47:0]        re2_r, im2_r, nreg_r;
  logic [5:0]         e_r;
  logic [30:0]        m_r;
  logic [15:0]        frac_r;
  logic [61:0]        msq;
  logic signed [22:0] dval;
  logic signed [49:0] dbx_r;
  logic [47:0]        num;
  logic [57:0]        qv;
  logic [13:0]        t_r;
  logic [28:0]        tq;
  logic [9:0]         lvl;
  logic [9:0]         lvl_even_r;
  logic [5:0]         row_r;
  logic               last_bin;

  srf_ram #(.WIDTH(16), .DEPTH(N_PTS)) u_hist (
    .clk(clk), .we(cmd.store), .waddr(wp_r), .wdata(in_req.sample),
    .raddr(haddr), .rdata(hrdata)
  );

  srf_ram #(.WIDTH(48), .DEPTH(N_PTS)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata)
  );

  assign haddr  = wp_r + cmd.idx;
  assign half9  = 9'd1 << (cmd.stage - 4'd1);
  assign hmask  = half9 - 9'd1;
  assign addr_a = ((cmd.idx & ~hmask) << 1) | (cmd.idx & hmask);
  assign addr_b = addr_a | half9;
  assign tw_idx = 8'((cmd.idx & hmask) << (4'(LOG2_N) - cmd.stage));

  assign rd_re = wk_rdata[47:24];
  assign rd_im = wk_rdata[23:0];
  assign wr    = tw_r[31:16];
  assign wi    = tw_r[15:0];

  always_comb begin
    wk_raddr = cmd.idx;
    if (cmd.op == S_BF_RA) wk_raddr = addr_a;
    else if (cmd.op == S_BF_RB) wk_raddr = addr_b;
    wk_we    = (cmd.op == S_LD_WR) || (cmd.op == S_BF_WA) || (cmd.op == S_BF_WB);
    wk_waddr = addr_b;
    wk_wdata = {br_r, bi_r};
    if (cmd.op == S_LD_WR) begin
      wk_waddr = bit_rev(cmd.idx);
      wk_wdata = {sat24(48'((lprod_r + 34'sd128) >>> 8)), 24'd0};
    end else if (cmd.op == S_BF_WA) begin
      wk_waddr = addr_a;
      wk_wdata = {ar_r, ai_r};
    end
  end

  assign lx = hv_r ? $signed(hrdata) : 16'sd0;
  assign ur = 42'(a_re_r) <<< 14;
  assign ui = 42'(a_im_r) <<< 14;
  assign vr = 42'(p_rr_r) - 42'(p_ii_r);
  assign vi = 42'(p_ri_r) + 42'(p_ir_r);

  assign msq  = 62'(m_r) * 62'(m_r);
  assign dval = $signed({1'b0, e_r, frac_r}) - 23'sd2883584;
  assign num  = 48'(dbx_r + (50'sd80 <<< 40));
  assign qv   = ({10'd0, num} << 10) - {10'd0, num} + (58'd5 << 43);
  assign tq   = 29'(t_r) * 29'd52429;
  assign lvl  = (t_r >= 14'd5120) ? 10'd1023 : tq[27:18];
  assign last_bin = (cmd.idx == 9'(N_BINS - 1));

  always_ff @(posedge clk) begin
    case (cmd.op)
      S_LD_RD: begin
        win_r <= WIN_ROM[cmd.idx];
        hv_r  <= fill_r[9] || ({1'b0, haddr} < fill_r);
      end
      S_LD_MUL: lprod_r <= lx * win_r;
      S_BF_RB: begin
        a_re_r <= rd_re;
        a_im_r <= rd_im;
        tw_r   <= TW_ROM[tw_idx];
      end
      S_BF_MUL: begin
        p_rr_r <= rd_re * wr;
        p_ii_r <= rd_im * wi;
        p_ri_r <= rd_re * wi;
        p_ir_r <= rd_im * wr;
      end
      S_BF_ADD: begin
        ar_r <= sat24(48'((ur + vr + 42'sd16384) >>> 15));
        ai_r <= sat24(48'((ui + vi + 42'sd16384) >>> 15));
        br_r <= sat24(48'((ur - vr + 42'sd16384) >>> 15));
        bi_r <= sat24(48'((ui - vi + 42'sd16384) >>> 15));
      end
      S_MG_MUL: begin
        re2_r <= 48'(rd_re) * 48'(rd_re);
        im2_r <= 48'(rd_im) * 48'(rd_im);
      end
      S_MG_SUM: begin
        nreg_r <= re2_r + im2_r;
        e_r    <= 6'd47;
        frac_r <= '0;
      end
      S_MG_NORM: begin
        if (nreg_r[47]) begin
          m_r <= nreg_r[47:17];
        end else if (nreg_r != '0) begin
          nreg_r <= nreg_r << 1;
          e_r    <= e_r - 6'd1;
        end
      end
      S_MG_SQ: begin
        if (msq[61]) begin
          m_r    <= msq[61:31];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r    <= msq[60:30];
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      S_MG_DB: dbx_r <= dval * DB_PER_LOG2;
      S_MG_LVL: begin
        if ((nreg_r == '0) || (dbx_r <= -(50'sd80 <<< 40))) t_r <= '0;
        else t_r <= qv[57:44];
      end
      S_MG_FIN: begin
        if (!cmd.idx[0]) lvl_even_r <= lvl;
        out_req.bin_pair    <= cmd.idx[6:1];
        out_req.level_even  <= lvl_even_r;
        out_req.level_odd   <= lvl;
        out_req.row_number  <= row_r;
        out_req.last_of_row <= last_bin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      fill_r     <= '0;
      row_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (cmd.op == S_MG_FIN) && cmd.idx[0];
      if (cmd.store) begin
        wp_r <= wp_r + 9'd1;
        if (!fill_r[9]) fill_r <= fill_r + 10'd1;
      end
      if ((cmd.op == S_MG_FIN) && last_bin) row_r <= row_r + 6'd1;
    end
  end

  assign stat.pw_zero  = (nreg_r == '0);
  assign stat.norm_top = nreg_r[47];

endmodule

@@ rtl/spectrogram_row_fft.sv @@
// Top level of the spectrogram row block: joins the controller and datapath.
// Depends on srf_pkg, srf_ctrl, srf_dp and srf_ram.
//
// Usage: a request on in_req is taken at a clock edge where start is high and
// busy is low. Every sample is written to a 512-entry ring. When the
// snapshot bit is set, busy rises and the block computes one row: 512 load
// steps (ring read, window multiply, memory write), 9 x 256 butterflies
// (one read and one write port on the work memory), then 128 bins (a
// zero-power bin skips the loops; otherwise the serial normalize loop and
// 16 serial squarings run). A sample without snapshot is only stored and
// busy stays low.
// Results leave on out_req with out_strobe high for one cycle, one request
// per bin pair, 64 per row, the last one flagged with last_of_row. The
// receiver cannot stall; it must take each request on its strobe cycle.
// Reset clears the ring position, the fill count (unwritten ring entries read
// as zero), the row counter and the controller; no clearing pass is needed.
`timescale 1ns / 1ps

module spectrogram_row_fft
  import srf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output out_req_t out_req,
  output logic     out_strobe
);

  srf_cmd_t  cmd;
  srf_stat_t stat;

  srf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .snapshot(in_req.snapshot),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  srf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_req(in_req), .stat(stat),
    .out_req(out_req), .out_strobe(out_strobe)
  );

endmodule
